### rtl/core/mbjet_pkg.sv
// ----------------------------------------------------------------------------
// mbjet_pkg
// Shared types, register indexes and helpers for the escape-time engine.
// ----------------------------------------------------------------------------
package mbjet_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int ITER_WIDTH  = 16;
    localparam int QF          = 28;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KIND  = 3'd0,
        REG_MAXIT = 3'd1,
        REG_FRE   = 3'd2,
        REG_FIM   = 3'd3,
        REG_BAIL  = 3'd4
    } cfg_index_t;

    localparam logic [2:0] KIND_JULIA = 3'd4;

    // sequencer states of the engine
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG_RE,
        ST_MAG_IM,
        ST_TEST,
        ST_MUL_RR,
        ST_MUL_II,
        ST_MUL_RI,
        ST_MUL_IR,
        ST_ROUND,
        ST_ADD,
        ST_DONE
    } state_t;

    // operation request to the shared multiplier
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
    } mul_rsp_t;

    function automatic logic signed [63:0] to_q28(input logic [COORD_WIDTH-1:0] v);
        logic signed [63:0] s;
        s = 64'(signed'(v));
        if (COORD_WIDTH - 4 >= QF)
            to_q28 = s >>> (COORD_WIDTH - 4 - QF);
        else
            to_q28 = s <<< (QF - (COORD_WIDTH - 4));
    endfunction

    // clamp a 128-bit signed value to +-lim
    function automatic logic signed [63:0] clamp128(input logic signed [127:0] x,
                                                    input logic signed [63:0] lim);
        if (x > 128'(lim))
            clamp128 = lim;
        else if (x < -128'(lim))
            clamp128 = -lim;
        else
            clamp128 = x[63:0];
    endfunction

endpackage

### rtl/core/multibrot_julia_escape_time.sv
// ----------------------------------------------------------------------------
// multibrot_julia_escape_time
// Escape-time engine: z <- z^p + c on a shared iterative multiplier.
// ----------------------------------------------------------------------------
// Flow: per iteration |z|^2 from two squares, the bailout test, then p-1
// rounds of four products and a rounding step, then the add of c; an unused
// kind goes straight to the result. Every product runs on the shared 64x64
// multiplier (four 32x32 steps). One pixel at a time: s_ready is low while
// a pixel is in work or its result waits.
// Reset: synchronous active-low aresetn restores register defaults and idles.
module multibrot_julia_escape_time (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [mbjet_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbjet_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [mbjet_pkg::COORD_WIDTH-1:0] s_pixel_re,
    input  logic signed [mbjet_pkg::COORD_WIDTH-1:0] s_pixel_im,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [15:0]                          m_iterations,
    output logic                                 m_escaped,
    output logic [63:0]                          m_final_mag_sq
);
    localparam logic signed [63:0] W_LIM = 64'sd1 <<< 62;
    localparam logic signed [63:0] Z_LIM = 64'sd1 <<< 48;
    localparam int ITW = mbjet_pkg::ITER_WIDTH;

    logic [2:0]  kind_reg;
    logic [15:0] maxit_reg;
    logic [mbjet_pkg::COORD_WIDTH-1:0] fre_reg, fim_reg;
    logic [16:0] bail_reg;

    mbjet_pkg::state_t state_reg, state_next;
    logic signed [63:0] zr_reg, zi_reg, wr_reg, wi_reg, cr_reg, ci_reg;
    logic signed [127:0] pa_reg, pb_reg;
    // real/imag product terms collected separately
    logic signed [127:0] ri_reg, ir_reg;
    logic [63:0]  mag_reg, sqa_reg;
    logic [2:0]   kcnt_reg;
    logic [2:0]   power_reg;
    logic [ITW-1:0] iter_reg;
    logic [ITW-1:0] limit_reg;
    logic [48:0]  thr_reg;
    logic         sat_reg;
    logic         wait_reg;
    logic [15:0]  res_it_reg;
    logic         res_esc_reg;
    logic [63:0]  res_mag_reg;

    mbjet_pkg::mul_req_t mreq;
    mbjet_pkg::mul_rsp_t mrsp;

    mbjet_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));

    // squared magnitude piece: product >>> 24, saturated to 64 bits
    logic [63:0] sq_sat;
    logic [64:0] mag_sum;
    logic signed [127:0] sq_sh;
    always_comb begin
        sq_sh   = signed'(mrsp.prod) >>> 24;
        sq_sat  = (sq_sh[127:64] != '0) ? '1 : sq_sh[63:0];
        mag_sum = 65'(sqa_reg) + 65'(sq_sat);
    end

    logic signed [127:0] re_sum, im_sum;
    logic signed [63:0]  zr_add, zi_add;
    logic signed [63:0]  wr_rnd, wi_rnd;
    always_comb begin
        re_sum = (pa_reg - pb_reg) >>> mbjet_pkg::QF;
        im_sum = (ri_reg + ir_reg) >>> mbjet_pkg::QF;
        wr_rnd = mbjet_pkg::clamp128(re_sum, W_LIM);
        wi_rnd = mbjet_pkg::clamp128(im_sum, W_LIM);
        zr_add = mbjet_pkg::clamp128(128'(wr_reg) + 128'(cr_reg), Z_LIM);
        zi_add = mbjet_pkg::clamp128(128'(wi_reg) + 128'(ci_reg), Z_LIM);
    end

    logic accept;
    assign s_ready = (state_reg == mbjet_pkg::ST_IDLE) && !wait_reg;
    assign accept  = s_valid && s_ready;
    logic escape_cond;
    assign escape_cond = (mag_reg > {thr_reg, 15'd0});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mbjet_pkg::ST_IDLE:   if (accept) state_next = (kind_reg > mbjet_pkg::KIND_JULIA) ?
                                      mbjet_pkg::ST_DONE : mbjet_pkg::ST_MAG_RE;
            mbjet_pkg::ST_MAG_RE: if (mrsp.done) state_next = mbjet_pkg::ST_MAG_IM;
            mbjet_pkg::ST_MAG_IM: if (mrsp.done) state_next = mbjet_pkg::ST_TEST;
            mbjet_pkg::ST_TEST:   state_next = (escape_cond || iter_reg >= limit_reg) ?
                                      mbjet_pkg::ST_DONE : mbjet_pkg::ST_MUL_RR;
            mbjet_pkg::ST_MUL_RR: if (mrsp.done) state_next = mbjet_pkg::ST_MUL_II;
            mbjet_pkg::ST_MUL_II: if (mrsp.done) state_next = mbjet_pkg::ST_MUL_RI;
            mbjet_pkg::ST_MUL_RI: if (mrsp.done) state_next = mbjet_pkg::ST_MUL_IR;
            mbjet_pkg::ST_MUL_IR: if (mrsp.done) state_next = mbjet_pkg::ST_ROUND;
            mbjet_pkg::ST_ROUND:  state_next = (kcnt_reg + 3'd1 >= power_reg) ?
                                      mbjet_pkg::ST_ADD : mbjet_pkg::ST_MUL_RR;
            mbjet_pkg::ST_ADD:    state_next = mbjet_pkg::ST_MAG_RE;
            mbjet_pkg::ST_DONE:   state_next = mbjet_pkg::ST_IDLE;
            default:              state_next = mbjet_pkg::ST_IDLE;
        endcase
    end

    logic signed [63:0] zinit_r, zinit_i, zr_next_v;
    always_comb begin
        if (kind_reg == mbjet_pkg::KIND_JULIA) begin
            zinit_r = mbjet_pkg::to_q28(s_pixel_re);
            zinit_i = mbjet_pkg::to_q28(s_pixel_im);
        end else begin
            zinit_r = mbjet_pkg::to_q28(fre_reg);
            zinit_i = mbjet_pkg::to_q28(fim_reg);
        end
        zr_next_v = zr_add;
    end

    // start a product on entry to each multiply state
    logic enter;
    always_comb begin
        enter = (state_next != state_reg) || (state_reg == mbjet_pkg::ST_ROUND &&
                 state_next == mbjet_pkg::ST_MUL_RR);
        mreq.start = 1'b0;
        mreq.a = '0;
        mreq.b = '0;
        unique case (state_next)
            mbjet_pkg::ST_MAG_RE: begin
                mreq.start = enter;
                mreq.a = (state_reg == mbjet_pkg::ST_IDLE) ? zinit_r : zr_next_v;
                mreq.b = mreq.a;
            end
            mbjet_pkg::ST_MAG_IM: begin
                mreq.start = enter; mreq.a = zi_reg; mreq.b = zi_reg;
            end
            mbjet_pkg::ST_MUL_RR: begin
                // w is loaded on this same edge: feed its new value
                mreq.start = enter;
                mreq.a = (state_reg == mbjet_pkg::ST_ROUND) ? wr_rnd : zr_reg;
                mreq.b = zr_reg;
            end
            mbjet_pkg::ST_MUL_II: begin
                mreq.start = enter; mreq.a = wi_reg; mreq.b = zi_reg;
            end
            mbjet_pkg::ST_MUL_RI: begin
                mreq.start = enter; mreq.a = wr_reg; mreq.b = zi_reg;
            end
            mbjet_pkg::ST_MUL_IR: begin
                mreq.start = enter; mreq.a = wi_reg; mreq.b = zr_reg;
            end
            default: mreq.start = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mbjet_pkg::ST_IDLE;
            kind_reg  <= 3'd0;
            maxit_reg <= 16'd256;
            fre_reg   <= '0;
            fim_reg   <= '0;
            bail_reg  <= 17'd65536;
            wait_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    mbjet_pkg::REG_KIND:  kind_reg  <= cfg_data[2:0];
                    mbjet_pkg::REG_MAXIT: maxit_reg <= cfg_data[15:0];
                    mbjet_pkg::REG_FRE:   fre_reg   <= cfg_data[mbjet_pkg::COORD_WIDTH-1:0];
                    mbjet_pkg::REG_FIM:   fim_reg   <= cfg_data[mbjet_pkg::COORD_WIDTH-1:0];
                    mbjet_pkg::REG_BAIL:  bail_reg  <= cfg_data[16:0];
                    default: ;
                endcase
            end
            if (state_reg == mbjet_pkg::ST_DONE)
                wait_reg <= 1'b1;
            else if (m_valid && m_ready)
                wait_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            mbjet_pkg::ST_IDLE: if (accept) begin
                zr_reg <= zinit_r;
                zi_reg <= zinit_i;
                sat_reg <= 1'b0;
                if (kind_reg == mbjet_pkg::KIND_JULIA) begin
                    cr_reg <= mbjet_pkg::to_q28(fre_reg);
                    ci_reg <= mbjet_pkg::to_q28(fim_reg);
                    power_reg <= 3'd2;
                end else begin
                    cr_reg <= mbjet_pkg::to_q28(s_pixel_re);
                    ci_reg <= mbjet_pkg::to_q28(s_pixel_im);
                    power_reg <= kind_reg + 3'd2;
                end
                iter_reg  <= '0;
                limit_reg <= maxit_reg[ITW-1:0];
                thr_reg   <= (bail_reg > 17'd65536) ? 49'd65536 << 32 - 15 :
                             49'(bail_reg) << 17;
                res_it_reg  <= '0;
                res_esc_reg <= 1'b0;
                res_mag_reg <= '0;
            end
            mbjet_pkg::ST_MAG_RE: if (mrsp.done) sqa_reg <= sq_sat;
            mbjet_pkg::ST_MAG_IM: if (mrsp.done) begin
                mag_reg <= mag_sum[64] ? '1 : mag_sum[63:0];
            end
            mbjet_pkg::ST_TEST: begin
                if (sat_reg) mag_reg <= '1;
                wr_reg   <= zr_reg;
                wi_reg   <= zi_reg;
                kcnt_reg <= 3'd1;
                if (state_next == mbjet_pkg::ST_DONE) begin
                    res_it_reg  <= 16'(iter_reg);
                    res_esc_reg <= iter_reg < limit_reg;
                    res_mag_reg <= (sat_reg) ? '1 : mag_reg;
                end
            end
            mbjet_pkg::ST_MUL_RR: if (mrsp.done) pa_reg <= mrsp.prod;
            mbjet_pkg::ST_MUL_II: if (mrsp.done) pb_reg <= mrsp.prod;
            mbjet_pkg::ST_MUL_RI: if (mrsp.done) ri_reg <= mrsp.prod;
            mbjet_pkg::ST_MUL_IR: if (mrsp.done) ir_reg <= mrsp.prod;
            mbjet_pkg::ST_ROUND: begin
                wr_reg   <= wr_rnd;
                wi_reg   <= wi_rnd;
                kcnt_reg <= kcnt_reg + 3'd1;
            end
            mbjet_pkg::ST_ADD: begin
                zr_reg   <= zr_add;
                zi_reg   <= zi_add;
                sat_reg  <= (zr_add == Z_LIM) || (zr_add == -Z_LIM) ||
                            (zi_add == Z_LIM) || (zi_add == -Z_LIM);
                iter_reg <= iter_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign m_valid        = wait_reg;
    assign m_iterations   = res_it_reg;
    assign m_escaped      = res_esc_reg;
    assign m_final_mag_sq = res_mag_reg;
endmodule

### rtl/core/mbjet_mul.sv
// ----------------------------------------------------------------------------
// mbjet_mul
// Iterative signed 64x64 multiplier: one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module mbjet_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  mbjet_pkg::mul_req_t req,
    output mbjet_pkg::mul_rsp_t rsp
);
    logic [63:0]  ua_reg, ub_reg;
    logic         neg_reg;
    logic [1:0]   step_reg;
    logic         busy_reg;
    logic [127:0] acc_reg;
    logic         done_reg;
    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] sh;

    always_comb begin
        pa = step_reg[0] ? ua_reg[63:32] : ua_reg[31:0];
        pb = step_reg[1] ? ub_reg[63:32] : ub_reg[31:0];
        pp = 64'(pa) * 64'(pb);
        sh = 128'(pp) << (7'(step_reg[0]) * 7'd32 + 7'(step_reg[1]) * 7'd32);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
                acc_reg  <= '0;
                ua_reg   <= req.a[63] ? 64'(-req.a) : req.a;
                ub_reg   <= req.b[63] ? 64'(-req.b) : req.b;
                neg_reg  <= req.a[63] ^ req.b[63];
            end else if (busy_reg) begin
                acc_reg  <= acc_reg + sh;
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = neg_reg ? 128'(-acc_reg) : acc_reg;
endmodule

### rtl/core/mbjet_checker.sv
// ----------------------------------------------------------------------------
// mbjet_checker
// Port-level checks on the escape-time engine.
// ----------------------------------------------------------------------------
module mbjet_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_iterations,
    input logic        m_escaped
);
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("second request taken");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_iterations) && $stable(m_escaped)))
        else $error("result dropped");
endmodule

bind multibrot_julia_escape_time mbjet_checker u_chk (.*);

### bench/tb_multibrot_julia_escape_time.sv
// ----------------------------------------------------------------------------
// tb_multibrot_julia_escape_time
// Self-checking bench for the escape-time engine. A bit-accurate predictor
// computes the iteration count, escape flag and final |z|^2 for each accepted
// pixel. The run steps through Mandelbrot powers 2..5, Julia, unused kinds
// and edge settings of limit and bailout, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_multibrot_julia_escape_time;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_P2 = 3'd0;
    localparam logic [2:0] KIND_P3 = 3'd1;
    localparam logic [2:0] KIND_P4 = 3'd2;
    localparam logic [2:0] KIND_P5 = 3'd3;
    localparam logic [2:0] KIND_BAD_LO = 3'd5;
    localparam logic [2:0] KIND_BAD_HI = 3'd7;
    localparam logic signed [127:0] PROD_LIM = 128'sh4000_0000_0000_0000;
    localparam logic signed [63:0]  Z_LIM    = 64'sh0001_0000_0000_0000;
    localparam logic [16:0] BAIL_MAX = 17'd65536;

    typedef struct {
        logic [15:0] iterations;
        logic        escaped;
        logic [63:0] mag;
    } pix_res_t;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
    } pixel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [mbjet_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mbjet_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic signed [mbjet_pkg::COORD_WIDTH-1:0] s_pixel_re = '0;
    logic signed [mbjet_pkg::COORD_WIDTH-1:0] s_pixel_im = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_iterations;
    logic        m_escaped;
    logic [63:0] m_final_mag_sq;

    // shadow of the block's registers
    logic [2:0]  cur_kind = KIND_P2;
    logic [15:0] cur_maxit = 16'd256;
    logic [31:0] cur_fre = '0;
    logic [31:0] cur_fim = '0;
    logic [16:0] cur_bail = 17'd65536;

    pixel_t   pending_px[$];
    pix_res_t expected_res[$];
    int       n_err = 0;
    int       n_added = 0;
    int       n_sent = 0;
    int       n_got = 0;
    int       n_escaped = 0;
    int       sent_per_kind[8];
    bit       req_taken = 0;
    bit       quiet = 0;
    bit       hold_done = 0;
    int       hold_left = 0;

    multibrot_julia_escape_time i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pixel_re(s_pixel_re), .s_pixel_im(s_pixel_im),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_iterations(m_iterations), .m_escaped(m_escaped),
        .m_final_mag_sq(m_final_mag_sq)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic signed [63:0] coord_q28(input logic [31:0] v);
        return $signed({{32{v[31]}}, v});
    endfunction

    function automatic logic signed [63:0] clamp_prod(input logic signed [127:0] x);
        if (x > PROD_LIM) return PROD_LIM[63:0];
        if (x < -PROD_LIM) return -PROD_LIM[63:0];
        return x[63:0];
    endfunction

    function automatic logic signed [63:0] clamp_z(input logic signed [63:0] v);
        if (v > Z_LIM) return Z_LIM;
        if (v < -Z_LIM) return -Z_LIM;
        return v;
    endfunction

    function automatic logic [63:0] square_q32(input logic signed [63:0] v);
        logic signed [127:0] w;
        w = v;
        w = (w * w) >>> 24;
        return (w[127:64] != 0) ? '1 : w[63:0];
    endfunction

    function automatic logic [63:0] magnitude_sq(input logic signed [63:0] re,
                                                 input logic signed [63:0] im);
        logic [64:0] s;
        s = {1'b0, square_q32(re)} + {1'b0, square_q32(im)};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic pix_res_t predict_pixel(input logic [31:0] px_re,
                                               input logic [31:0] px_im);
        pix_res_t r;
        logic signed [63:0] zr, zi, cr, ci, wr, wi;
        logic signed [127:0] ar, ai, br, bi, pre, pim;
        logic [63:0] thr, mag;
        logic [15:0] iter;
        int power;
        r = '{0, 0, 0};
        if (cur_kind > mbjet_pkg::KIND_JULIA) return r;
        if (cur_kind == mbjet_pkg::KIND_JULIA) begin
            power = 2;
            zr = coord_q28(px_re); zi = coord_q28(px_im);
            cr = coord_q28(cur_fre); ci = coord_q28(cur_fim);
        end else begin
            power = cur_kind + 2;
            zr = coord_q28(cur_fre); zi = coord_q28(cur_fim);
            cr = coord_q28(px_re); ci = coord_q28(px_im);
        end
        thr = 64'(cur_bail > BAIL_MAX ? BAIL_MAX : cur_bail) << 32;
        iter = 0;
        mag = magnitude_sq(zr, zi);
        while (mag <= thr && iter < cur_maxit) begin
            wr = zr; wi = zi;
            for (int k = 1; k < power; k++) begin
                ar = wr; ai = wi; br = zr; bi = zi;
                pre = (ar * br - ai * bi) >>> 28;
                pim = (ar * bi + ai * br) >>> 28;
                wr = clamp_prod(pre);
                wi = clamp_prod(pim);
            end
            zr = clamp_z(wr + cr);
            zi = clamp_z(wi + ci);
            mag = magnitude_sq(zr, zi);
            iter++;
        end
        r.iterations = iter;
        r.escaped = iter < cur_maxit;
        r.mag = mag;
        return r;
    endfunction

    // accept requests and results at the rising edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_res.push_back(predict_pixel(s_pixel_re, s_pixel_im));
            sent_per_kind[cur_kind]++;
            n_sent++;
            req_taken = 1;
        end
        if (aresetn && m_valid && m_ready) begin
            pix_res_t e;
            n_got++;
            if (expected_res.size() == 0) begin
                $error("unexpected result: iterations %0d", m_iterations);
                n_err++;
            end else begin
                e = expected_res.pop_front();
                if (m_iterations !== e.iterations) begin
                    $error("iterations: expected %0d, got %0d", e.iterations, m_iterations);
                    n_err++;
                end
                if (m_escaped !== e.escaped) begin
                    $error("escaped: expected %0d, got %0d", e.escaped, m_escaped);
                    n_err++;
                end
                if (m_final_mag_sq !== e.mag) begin
                    $error("final_mag_sq: expected %h, got %h", e.mag, m_final_mag_sq);
                    n_err++;
                end
                if (e.escaped) n_escaped++;
            end
        end
    end

    // request driver: hold until taken, then advance
    always @(negedge aclk) begin
        if (!(s_valid && !req_taken)) begin
            req_taken = 0;
            if (pending_px.size() != 0 && aresetn && (quiet || $urandom_range(99) >= 8))
            begin
                pixel_t p;
                p = pending_px.pop_front();
                s_valid <= 1'b1;
                s_pixel_re <= p.re;
                s_pixel_im <= p.im;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side, with one long hold-off to back up the block
    always @(negedge aclk) begin
        if (!hold_done && n_got >= 40) begin
            hold_done <= 1;
            hold_left <= 1500;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || $urandom_range(99) >= 8;
        end
    end

    task automatic cfg_write(input mbjet_pkg::cfg_index_t idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            mbjet_pkg::REG_KIND:  cur_kind = val[2:0];
            mbjet_pkg::REG_MAXIT: cur_maxit = val[15:0];
            mbjet_pkg::REG_FRE:   cur_fre = val;
            mbjet_pkg::REG_FIM:   cur_fim = val;
            mbjet_pkg::REG_BAIL:  cur_bail = val[16:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // wait until every queued pixel has come back as a result
    task automatic wait_idle();
        wait (n_got == n_added);
        repeat (20) @(posedge aclk);
    endtask

    task automatic setup(input logic [2:0] kind, input logic [15:0] maxit,
                         input logic [31:0] fre, input logic [31:0] fim,
                         input logic [16:0] bail);
        wait_idle();
        cfg_write(mbjet_pkg::REG_KIND, 32'(kind));
        cfg_write(mbjet_pkg::REG_MAXIT, 32'(maxit));
        cfg_write(mbjet_pkg::REG_FRE, fre);
        cfg_write(mbjet_pkg::REG_FIM, fim);
        cfg_write(mbjet_pkg::REG_BAIL, 32'(bail));
    endtask

    task automatic add_px(input logic [31:0] re, input logic [31:0] im);
        n_added++;
        pending_px.push_back('{re, im});
    endtask

    function automatic logic [31:0] near_coord();
        return 32'($urandom_range(32'h4000_0000)) - 32'h2000_0000;
    endfunction

    // mostly points around the set, some anywhere in range
    task automatic add_random(input int n);
        repeat (n) begin
            if ($urandom_range(7) == 0) add_px($urandom, $urandom);
            else add_px(near_coord(), near_coord());
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // defaults: power 2, limit 256, start 0, bailout 65536
        add_px(32'h0, 32'h0);
        add_px(32'h7fff_ffff, 32'h7fff_ffff);
        add_px(32'h8000_0000, 32'h8000_0000);
        add_px(32'h8000_0000, 32'h7fff_ffff);
        add_px(32'hffff_ffff, 32'hffff_ffff);
        add_px(32'h1000_0000, 32'h0);
        setup(KIND_P3, 16, 32'h0, 32'h0, 4);
        add_px(32'hf000_0000, 32'h0800_0000);
        add_px(32'h0, 32'h0);
        setup(KIND_P4, 16, 32'h0, 32'h0, 4);
        add_px(32'h0400_0000, 32'hfc00_0000);
        add_px(32'h7fff_ffff, 32'h0);
        setup(KIND_P5, 16, 32'h7fff_ffff, 32'h8000_0000, 1);
        add_px(32'h0, 32'h0);
        setup(mbjet_pkg::KIND_JULIA, 16, 32'h8000_0000, 32'h7fff_ffff, 65536);
        add_px(32'h0, 32'h0);
        setup(mbjet_pkg::KIND_JULIA, 12, 32'hf400_0000, 32'h0300_0000, 4);
        add_px(32'h0100_0000, 32'h0);
        setup(KIND_BAD_LO, 16, 32'h0, 32'h0, 4);
        add_px(32'h1234_5678, 32'h8765_4321);
        setup(KIND_BAD_HI, 16, 32'h0, 32'h0, 4);
        add_px(32'h0, 32'h0);
        // zero limit, zero bailout, bailout above the cap
        setup(KIND_P2, 0, 32'h0800_0000, 32'h0, 4);
        add_px(32'h0, 32'h0);
        setup(KIND_P2, 16, 32'h0, 32'h0, 0);
        add_px(32'h0, 32'h0);
        add_px(32'h0000_0001, 32'h0);
        setup(KIND_P2, 16, 32'h0, 32'h0, 17'h1ffff);
        add_px(32'hf000_0000, 32'h0);
        // highest limit, only pixels that escape after one iteration
        setup(KIND_P2, 16'hffff, 32'h0, 32'h0, 4);
        for (int i = 0; i < 8; i++)
            add_px(i[0] ? 32'h4000_0000 | $urandom_range(32'h3fff_ffff) : 32'h8000_0000,
                   $urandom);

        quiet = 1;
        setup(KIND_P2, 16'($urandom_range(8, 48)), 32'h0, 32'h0, 4);
        add_random(100);
        setup(KIND_P2, 16'($urandom_range(8, 48)), 32'h0, 32'h0, 4);
        quiet = 0;
        add_random(60);
        setup(KIND_P3, 16'($urandom_range(8, 24)), 32'h0, 32'h0, 4);
        add_random(70);
        setup(KIND_P4, 16'($urandom_range(8, 24)), near_coord() >>> 2, near_coord() >>> 2, 4);
        add_random(70);
        setup(KIND_P5, 16'($urandom_range(8, 24)), 32'h0, 32'h0, 4);
        add_random(70);
        setup(mbjet_pkg::KIND_JULIA, 32, near_coord(), near_coord(), 4);
        add_random(60);
        for (int i = 0; i < 6; i++) begin
            setup(3'($urandom_range(4)), 16'($urandom_range(1, 20)), $urandom, $urandom,
                  17'($urandom_range(1, 65536)));
            add_random(10);
        end

        wait_idle();
        repeat (200) @(posedge aclk);
        $display("Covered %0d pixels (p2 %0d, p3 %0d, p4 %0d, p5 %0d, julia %0d, unused %0d),",
                 n_sent, sent_per_kind[0], sent_per_kind[1], sent_per_kind[2],
                 sent_per_kind[3], sent_per_kind[4],
                 sent_per_kind[5] + sent_per_kind[6] + sent_per_kind[7]);
        $display("%0d results checked, %0d escaped, %0d errors.", n_got, n_escaped, n_err);
        if (n_err == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
